// ===== src/tsgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsgr_pkg
// Shared types, codes and defaults of the text screen glyph renderer.
// ----------------------------------------------------------------------------
package tsgr_pkg;

	// default sizes
	localparam int SCREEN_BYTES_DEF  = 16384;
	localparam int FONT_BYTES_DEF    = 4096;
	localparam int BORDER_OFFSET_DEF = 10;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int OFFSET_W = 14;
	localparam int FADDR_W  = 12;
	localparam int DATA_W   = 8;
	localparam int KIND_W   = 2;
	localparam int PIX_W    = 11;
	localparam int CFGIDX_W = 2;
	localparam int CFGDAT_W = 8;

	// register widths
	localparam int HEIGHT_W = 5;
	localparam int ROWS_W   = 7;
	localparam int COLS_W   = 8;
	localparam int CELLS_W  = 15;
	localparam int GADDR_W  = 13;

	// register index codes
	localparam logic [CFGIDX_W-1:0] REG_CHAR_HEIGHT = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_SCREEN_ROWS = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_SCREEN_COLS = 2'd2;

	// register limits and reset values
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 5'd8;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 5'd16;
	localparam logic [ROWS_W-1:0]   ROWS_MIN   = 7'd15;
	localparam logic [ROWS_W-1:0]   ROWS_MAX   = 7'd75;
	localparam logic [ROWS_W-1:0]   ROWS_RST   = 7'd25;
	localparam logic [COLS_W-1:0]   COLS_MIN   = 8'd32;
	localparam logic [COLS_W-1:0]   COLS_MAX   = 8'd132;
	localparam logic [COLS_W-1:0]   COLS_RST   = 8'd80;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FONT  = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROW   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	localparam logic [DATA_W-1:0] SPACE_CODE = 8'h20;
	localparam logic [DATA_W-1:0] ERROR_CODE = 8'hFF;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic font_write;
		logic size;
		logic scr_read;
		logic scr_write;
		logic emit_error;
		logic emit_read;
		logic div_step;
		logic scale;
		logic rows;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic div_last;
		logic rows_done;
	} dp_stat_t;

endpackage

// ===== src/text_screen_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_screen_glyph_renderer
// Memory-mapped text screen with font store and glyph row output.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen memory to spaces, one cell per
// cycle, over all SCREEN_BYTES cells; busy stays high meanwhile and config
// writes are still taken (cfg_ready is always high). A font write gives no
// result and leaves the block idle. An out-of-range access puts its single
// result on the ports after the SIZE and CHECK states, a screen read after
// SIZE, CHECK and READ; busy drops as that result appears. A screen write
// runs a one bit per cycle restoring divider over the 14-bit offset by the
// column count, then streams one glyph row per cycle from the font memory
// read port through the SCALE state and the font read stage; busy drops as
// the last row appears. Results appear for exactly one cycle under strobe;
// there is no backpressure, so the receiver must take every result when
// strobe is high.
module text_screen_glyph_renderer #(
	parameter int SCREEN_BYTES  = tsgr_pkg::SCREEN_BYTES_DEF,
	parameter int FONT_BYTES    = tsgr_pkg::FONT_BYTES_DEF,
	parameter int BORDER_OFFSET = tsgr_pkg::BORDER_OFFSET_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [tsgr_pkg::OPCODE_W-1:0]    opcode,
	input  logic [tsgr_pkg::OFFSET_W-1:0]    offset,
	input  logic [tsgr_pkg::FADDR_W-1:0]     font_address,
	input  logic [tsgr_pkg::DATA_W-1:0]      data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsgr_pkg::CFGIDX_W-1:0]    cfg_index,
	input  logic [tsgr_pkg::CFGDAT_W-1:0]    cfg_data,
	output logic                             strobe,
	output logic [tsgr_pkg::KIND_W-1:0]      kind,
	output logic [tsgr_pkg::DATA_W-1:0]      read_data,
	output logic [tsgr_pkg::PIX_W-1:0]       pixel_x,
	output logic [tsgr_pkg::PIX_W-1:0]       pixel_y,
	output logic [tsgr_pkg::DATA_W-1:0]      row_bits,
	output logic                             last
);

	tsgr_pkg::dp_cmd_t  cmd;
	tsgr_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tsgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tsgr_datapath #(
		.SCREEN_BYTES  (SCREEN_BYTES),
		.FONT_BYTES    (FONT_BYTES),
		.BORDER_OFFSET (BORDER_OFFSET)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.offset       (offset),
		.font_address (font_address),
		.data         (data),
		.strobe       (strobe),
		.kind         (kind),
		.read_data    (read_data),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.row_bits     (row_bits),
		.last         (last)
	);

endmodule

// ===== src/tsgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsgr_ctrl
// Sequencer: screen clear, request decode, divide, glyph row emission.
// ----------------------------------------------------------------------------
module tsgr_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tsgr_pkg::OPCODE_W-1:0]    opcode,
	input  tsgr_pkg::dp_stat_t               stat,
	output tsgr_pkg::dp_cmd_t                cmd,
	output logic                             busy
);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_SIZE   = 8'b0000_0100,
		ST_CHECK  = 8'b0000_1000,
		ST_READ   = 8'b0001_0000,
		ST_DIVIDE = 8'b0010_0000,
		ST_SCALE  = 8'b0100_0000,
		ST_ROWS   = 8'b1000_0000
	} state_t;

	state_t                          state_q, state_d;
	logic [tsgr_pkg::OPCODE_W-1:0]   op_q;
	logic                            accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			op_q    <= tsgr_pkg::OP_READ;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= opcode;
			end
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load       = 1'b1;
					cmd.font_write = (opcode == tsgr_pkg::OP_FONT);
					if (opcode == tsgr_pkg::OP_READ || opcode == tsgr_pkg::OP_WRITE) begin
						state_d = ST_SIZE;
					end
				end
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				if (!stat.in_range) begin
					cmd.emit_error = 1'b1;
					state_d        = ST_IDLE;
				end else if (op_q == tsgr_pkg::OP_WRITE) begin
					cmd.scr_write = 1'b1;
					state_d       = ST_DIVIDE;
				end else begin
					cmd.scr_read = 1'b1;
					state_d      = ST_READ;
				end
			end
			ST_READ: begin
				cmd.emit_read = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_ROWS;
			end
			ST_ROWS: begin
				cmd.rows = 1'b1;
				if (stat.rows_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/tsgr_datapath.sv =====
// ----------------------------------------------------------------------------
// tsgr_datapath
// Registers, screen and font memories, offset divider and result register.
// ----------------------------------------------------------------------------
module tsgr_datapath #(
	parameter int SCREEN_BYTES  = tsgr_pkg::SCREEN_BYTES_DEF,
	parameter int FONT_BYTES    = tsgr_pkg::FONT_BYTES_DEF,
	parameter int BORDER_OFFSET = tsgr_pkg::BORDER_OFFSET_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsgr_pkg::dp_cmd_t                cmd,
	output tsgr_pkg::dp_stat_t               stat,
	input  logic                             cfg_we,
	input  logic [tsgr_pkg::CFGIDX_W-1:0]    cfg_index,
	input  logic [tsgr_pkg::CFGDAT_W-1:0]    cfg_data,
	input  logic [tsgr_pkg::OFFSET_W-1:0]    offset,
	input  logic [tsgr_pkg::FADDR_W-1:0]     font_address,
	input  logic [tsgr_pkg::DATA_W-1:0]      data,
	output logic                             strobe,
	output logic [tsgr_pkg::KIND_W-1:0]      kind,
	output logic [tsgr_pkg::DATA_W-1:0]      read_data,
	output logic [tsgr_pkg::PIX_W-1:0]       pixel_x,
	output logic [tsgr_pkg::PIX_W-1:0]       pixel_y,
	output logic [tsgr_pkg::DATA_W-1:0]      row_bits,
	output logic                             last
);

	localparam int SIDX_W = $clog2(SCREEN_BYTES);
	localparam int FIDX_W = $clog2(FONT_BYTES);
	localparam int DIV_STEPS = tsgr_pkg::OFFSET_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int QUO_W  = tsgr_pkg::ROWS_W;

	localparam logic [SIDX_W-1:0] CLR_LAST = SIDX_W'(SCREEN_BYTES - 1);
	localparam logic [tsgr_pkg::CELLS_W-1:0] CELLS_MAX = tsgr_pkg::CELLS_W'(SCREEN_BYTES);
	localparam logic [tsgr_pkg::GADDR_W-1:0] FONT_LIM = tsgr_pkg::GADDR_W'(FONT_BYTES);
	localparam logic [tsgr_pkg::PIX_W-1:0] BORDER = tsgr_pkg::PIX_W'(BORDER_OFFSET);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

	// memories
	logic [tsgr_pkg::DATA_W-1:0] screen_mem [SCREEN_BYTES];
	logic [tsgr_pkg::DATA_W-1:0] font_mem [FONT_BYTES];

	// configuration
	logic [tsgr_pkg::HEIGHT_W-1:0] height_q;
	logic [tsgr_pkg::ROWS_W-1:0]   rows_q;
	logic [tsgr_pkg::COLS_W-1:0]   cols_q;

	// request and working registers
	logic [SIDX_W-1:0]                clr_q;
	logic [tsgr_pkg::OFFSET_W-1:0]    off_q;
	logic [tsgr_pkg::DATA_W-1:0]      data_q;
	logic [tsgr_pkg::CELLS_W-1:0]     cells_q;
	logic [tsgr_pkg::DATA_W-1:0]      scr_rd_q;
	logic [tsgr_pkg::COLS_W-1:0]      rem_q;
	logic [tsgr_pkg::OFFSET_W-1:0]    quo_q;
	logic [DCNT_W-1:0]                dcnt_q;
	logic [tsgr_pkg::PIX_W-1:0]       x_q;
	logic [tsgr_pkg::PIX_W-1:0]       y_q;
	logic [tsgr_pkg::GADDR_W-1:0]     base_q;
	logic [tsgr_pkg::HEIGHT_W-1:0]    row_q;

	// font read stage
	logic                             pend_s1;
	logic [tsgr_pkg::HEIGHT_W-1:0]    pend_row_s1;
	logic                             pend_oob_s1;
	logic [tsgr_pkg::DATA_W-1:0]      font_rd_s1;

	logic [tsgr_pkg::CELLS_W-1:0]     cells_prod;
	logic [tsgr_pkg::COLS_W:0]        trial;
	logic                             trial_ge;
	logic [tsgr_pkg::GADDR_W-1:0]     glyph_addr;
	logic                             issue;
	logic                             font_in_range;

	function automatic logic [tsgr_pkg::CFGDAT_W-1:0] clamp(
		input logic [tsgr_pkg::CFGDAT_W-1:0] v,
		input logic [tsgr_pkg::CFGDAT_W-1:0] lo,
		input logic [tsgr_pkg::CFGDAT_W-1:0] hi
	);
		logic [tsgr_pkg::CFGDAT_W-1:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	assign cells_prod = tsgr_pkg::CELLS_W'(rows_q) * tsgr_pkg::CELLS_W'(cols_q);

	// restoring division step: offset by column count, one quotient bit a cycle
	assign trial    = {rem_q, quo_q[tsgr_pkg::OFFSET_W-1]};
	assign trial_ge = (trial >= {1'b0, cols_q});

	assign glyph_addr    = base_q + tsgr_pkg::GADDR_W'(row_q);
	assign issue         = cmd.rows && (row_q < height_q);
	assign font_in_range = ({1'b0, font_address} < FONT_LIM);

	assign stat.clear_last = (clr_q == CLR_LAST);
	assign stat.in_range   = ({1'b0, off_q} < cells_q);
	assign stat.div_last   = (dcnt_q == DCNT_LAST);
	assign stat.rows_done  = pend_s1 && ((pend_row_s1 + 1'b1) == height_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= tsgr_pkg::HEIGHT_MIN;
			rows_q   <= tsgr_pkg::ROWS_RST;
			cols_q   <= tsgr_pkg::COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsgr_pkg::REG_CHAR_HEIGHT: begin
					height_q <= tsgr_pkg::HEIGHT_W'(clamp(
						{3'b000, cfg_data[tsgr_pkg::HEIGHT_W-1:0]},
						{3'b000, tsgr_pkg::HEIGHT_MIN}, {3'b000, tsgr_pkg::HEIGHT_MAX}));
				end
				tsgr_pkg::REG_SCREEN_ROWS: begin
					rows_q <= tsgr_pkg::ROWS_W'(clamp(
						{1'b0, cfg_data[tsgr_pkg::ROWS_W-1:0]},
						{1'b0, tsgr_pkg::ROWS_MIN}, {1'b0, tsgr_pkg::ROWS_MAX}));
				end
				tsgr_pkg::REG_SCREEN_COLS: begin
					cols_q <= clamp(cfg_data, tsgr_pkg::COLS_MIN, tsgr_pkg::COLS_MAX);
				end
				default: begin
				end
			endcase
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			dcnt_q  <= '0;
			row_q   <= '0;
			pend_s1 <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.size) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.scale) begin
				row_q <= '0;
			end else if (issue) begin
				row_q <= row_q + 1'b1;
			end
			pend_s1 <= issue;
			strobe  <= cmd.emit_error || cmd.emit_read || pend_s1;
		end
	end

	// request payload and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q  <= offset;
			data_q <= data;
		end
		if (cmd.size) begin
			cells_q <= (cells_prod > CELLS_MAX) ? CELLS_MAX : cells_prod;
			rem_q   <= '0;
			quo_q   <= off_q;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? tsgr_pkg::COLS_W'(trial - {1'b0, cols_q})
			                  : trial[tsgr_pkg::COLS_W-1:0];
			quo_q <= {quo_q[tsgr_pkg::OFFSET_W-2:0], trial_ge};
		end
		if (cmd.scale) begin
			x_q    <= BORDER + tsgr_pkg::PIX_W'({rem_q, 3'b000});
			y_q    <= BORDER + tsgr_pkg::PIX_W'(quo_q[QUO_W-1:0])
			                 * tsgr_pkg::PIX_W'(height_q);
			base_q <= tsgr_pkg::GADDR_W'(data_q) * tsgr_pkg::GADDR_W'(height_q);
		end
		if (issue) begin
			pend_row_s1 <= row_q;
			pend_oob_s1 <= (glyph_addr >= FONT_LIM);
		end
	end

	// screen memory: clear sweep after reset, one port
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			screen_mem[clr_q] <= tsgr_pkg::SPACE_CODE;
		end else if (cmd.scr_write) begin
			screen_mem[off_q[SIDX_W-1:0]] <= data_q;
		end
		if (cmd.scr_read) begin
			scr_rd_q <= screen_mem[off_q[SIDX_W-1:0]];
		end
	end

	// font memory
	always_ff @(posedge clk) begin
		if (cmd.font_write && font_in_range) begin
			font_mem[font_address[FIDX_W-1:0]] <= data;
		end
		if (issue) begin
			font_rd_s1 <= font_mem[glyph_addr[FIDX_W-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		priority if (cmd.emit_error) begin
			kind      <= tsgr_pkg::KIND_ERROR;
			read_data <= tsgr_pkg::ERROR_CODE;
			pixel_x   <= '0;
			pixel_y   <= '0;
			row_bits  <= '0;
			last      <= 1'b1;
		end else if (cmd.emit_read) begin
			kind      <= tsgr_pkg::KIND_READ;
			read_data <= scr_rd_q;
			pixel_x   <= '0;
			pixel_y   <= '0;
			row_bits  <= '0;
			last      <= 1'b1;
		end else if (pend_s1) begin
			kind      <= tsgr_pkg::KIND_ROW;
			read_data <= '0;
			pixel_x   <= x_q;
			pixel_y   <= y_q + tsgr_pkg::PIX_W'(pend_row_s1);
			row_bits  <= pend_oob_s1 ? '0 : font_rd_s1;
			last      <= stat.rows_done;
		end else begin
		end
	end

endmodule

// ===== test/tsgr_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsgr_result_checker
// Watches the request, register and result ports of the glyph renderer,
// keeps its own image of the screen, font and size registers, and checks
// every strobed result against the oldest predicted one.
// ----------------------------------------------------------------------------
module tsgr_result_checker
	import tsgr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [OFFSET_W-1:0] offset,
	input  logic [FADDR_W-1:0]  font_address,
	input  logic [DATA_W-1:0]   data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFGIDX_W-1:0] cfg_index,
	input  logic [CFGDAT_W-1:0] cfg_data,
	input  logic                strobe,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DATA_W-1:0]   read_data,
	input  logic [PIX_W-1:0]    pixel_x,
	input  logic [PIX_W-1:0]    pixel_y,
	input  logic [DATA_W-1:0]   row_bits,
	input  logic                last,
	output int                  fail_count,
	output int                  pending,
	output int                  results_checked
);

	localparam int GLYPH_WIDTH = 8;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] read_data;
		logic [PIX_W-1:0]  pixel_x;
		logic [PIX_W-1:0]  pixel_y;
		logic [DATA_W-1:0] row_bits;
		logic              last;
	} screen_result_t;

	screen_result_t    screen_results_due[$];
	logic [DATA_W-1:0] screen_image[SCREEN_BYTES_DEF];
	logic [DATA_W-1:0] font_image[FONT_BYTES_DEF];
	int                glyph_h;
	int                rows_q;
	int                cols_q;
	int                clr_idx;

	function automatic int saturate(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic apply_register(input logic [CFGIDX_W-1:0] idx,
			input logic [CFGDAT_W-1:0] value);
		case (idx)
			REG_CHAR_HEIGHT: glyph_h = saturate(int'(value[HEIGHT_W-1:0]),
					int'(HEIGHT_MIN), int'(HEIGHT_MAX));
			REG_SCREEN_ROWS: rows_q = saturate(int'(value[ROWS_W-1:0]),
					int'(ROWS_MIN), int'(ROWS_MAX));
			REG_SCREEN_COLS: cols_q = saturate(int'(value[COLS_W-1:0]),
					int'(COLS_MIN), int'(COLS_MAX));
			default: ;
		endcase
	endtask

	task automatic predict_access(input logic [OPCODE_W-1:0] op,
			input logic [OFFSET_W-1:0] off, input logic [FADDR_W-1:0] fa,
			input logic [DATA_W-1:0] d);
		screen_result_t res;
		int cells, col, line, base, a, r;
		cells = rows_q * cols_q;
		if (cells > SCREEN_BYTES_DEF)
			cells = SCREEN_BYTES_DEF;
		res = '0;
		case (op)
			OP_FONT: begin
				if (int'(fa) < FONT_BYTES_DEF)
					font_image[fa] = d;
			end
			OP_READ, OP_WRITE: begin
				res.last = 1'b1;
				if (int'(off) >= cells) begin
					res.kind = KIND_ERROR;
					res.read_data = ERROR_CODE;
					screen_results_due.push_back(res);
				end else if (op == OP_READ) begin
					res.kind = KIND_READ;
					res.read_data = screen_image[off];
					screen_results_due.push_back(res);
				end else begin
					screen_image[off] = d;
					col = int'(off) % cols_q;
					line = int'(off) / cols_q;
					base = int'(d) * glyph_h;
					for (r = 0; r < glyph_h; r++) begin
						a = base + r;
						res.kind = KIND_ROW;
						res.pixel_x = PIX_W'(BORDER_OFFSET_DEF + col * GLYPH_WIDTH);
						res.pixel_y = PIX_W'(BORDER_OFFSET_DEF + line * glyph_h + r);
						res.row_bits = (a < FONT_BYTES_DEF) ? font_image[FADDR_W'(a)] : '0;
						res.last = (r == glyph_h - 1);
						screen_results_due.push_back(res);
					end
				end
			end
			default: ;	// unused opcode: no effect
		endcase
	endtask

	task automatic check_result;
		screen_result_t want;
		if (screen_results_due.size() == 0) begin
			$error("unexpected result: kind %0d read_data %0d x %0d y %0d bits %0h last %0d",
					kind, read_data, pixel_x, pixel_y, row_bits, last);
			fail_count++;
		end else begin
			want = screen_results_due.pop_front();
			results_checked++;
			if (kind !== want.kind) begin
				$error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
				fail_count++;
			end
			if (read_data !== want.read_data) begin
				$error("read_data mismatch: expected %0d, actual %0d",
						want.read_data, read_data);
				fail_count++;
			end
			if (pixel_x !== want.pixel_x) begin
				$error("pixel_x mismatch: expected %0d, actual %0d", want.pixel_x, pixel_x);
				fail_count++;
			end
			if (pixel_y !== want.pixel_y) begin
				$error("pixel_y mismatch: expected %0d, actual %0d", want.pixel_y, pixel_y);
				fail_count++;
			end
			if (row_bits !== want.row_bits) begin
				$error("row_bits mismatch: expected %0h, actual %0h",
						want.row_bits, row_bits);
				fail_count++;
			end
			if (last !== want.last) begin
				$error("last mismatch: expected %0d, actual %0d", want.last, last);
				fail_count++;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		results_checked = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_results_due.delete();
			for (clr_idx = 0; clr_idx < SCREEN_BYTES_DEF; clr_idx++)
				screen_image[clr_idx] = SPACE_CODE;
			glyph_h = int'(HEIGHT_MIN);
			rows_q = int'(ROWS_RST);
			cols_q = int'(COLS_RST);
			pending = 0;
		end else begin
			// results first: nothing accepted at this edge can answer yet
			if (strobe === 1'b1)
				check_result();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (start && !busy)
				predict_access(opcode, offset, font_address, data);
			pending = screen_results_due.size();
		end
	end

endmodule

// ===== test/tb_text_screen_glyph_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_glyph_renderer
// Drives screen reads, screen writes and font writes into the renderer under
// several screen and glyph sizes and idle patterns; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_screen_glyph_renderer;
	import tsgr_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
	localparam logic [CFGIDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 32;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OPCODE_W-1:0] opcode;
	logic [OFFSET_W-1:0] offset;
	logic [FADDR_W-1:0]  font_address;
	logic [DATA_W-1:0]   data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFGIDX_W-1:0] cfg_index;
	logic [CFGDAT_W-1:0] cfg_data;
	logic                strobe;
	logic [KIND_W-1:0]   kind;
	logic [DATA_W-1:0]   read_data;
	logic [PIX_W-1:0]    pixel_x;
	logic [PIX_W-1:0]    pixel_y;
	logic [DATA_W-1:0]   row_bits;
	logic                last;

	logic item_took;
	logic cfg_took;
	int   fail_count;
	int   pending;
	int   results_checked;
	int   idle_pct;
	int   items_sent;
	int   reg_writes;
	int   written_cells[$];

	text_screen_glyph_renderer i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .offset(offset), .font_address(font_address), .data(data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .kind(kind), .read_data(read_data),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .row_bits(row_bits), .last(last)
	);

	tsgr_result_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .offset(offset), .font_address(font_address), .data(data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .kind(kind), .read_data(read_data),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .row_bits(row_bits), .last(last),
		.fail_count(fail_count), .pending(pending), .results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// handshake seen at the last rising edge, read back at the falling edge
	always @(posedge clk) begin
		item_took <= start && !busy;
		cfg_took <= cfg_valid && cfg_ready;
	end

	// called at a falling edge; leaves start high so requests can go back to back
	task automatic issue_access(input logic [OPCODE_W-1:0] op, input int off,
			input int fa, input int d);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		offset = OFFSET_W'(off);
		font_address = FADDR_W'(fa);
		data = DATA_W'(d);
		do @(negedge clk); while (!item_took);
		items_sent++;
	endtask

	task automatic write_register(input logic [CFGIDX_W-1:0] idx, input int value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFGDAT_W'(value);
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	// font writes give no result, so keep waiting after pending and busy clear
	task automatic drain;
		start = 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (8) @(negedge clk);
	endtask

	// screen writes only draw codes whose glyph bytes were preloaded
	task automatic random_access(input int cells, input int height);
		int r, off, d;
		logic [OPCODE_W-1:0] op;
		r = $urandom_range(99);
		off = $urandom_range(cells - 1);
		op = OP_WRITE;
		if (r < 40) begin
			op = OP_WRITE;
		end else if (r < 65) begin
			op = OP_READ;
			if (written_cells.size() != 0 && $urandom_range(1))
				off = written_cells[$urandom_range(written_cells.size() - 1)];
		end else if (r < 80) begin
			op = OP_FONT;
		end else if (r < 92) begin
			op = $urandom_range(1) ? OP_READ : OP_WRITE;
			off = $urandom_range((1 << OFFSET_W) - 1);
		end else if (r < 97) begin
			op = $urandom_range(1) ? OP_READ : OP_WRITE;
			off = cells - $urandom_range(1);	// last cell or first past the end
		end else begin
			op = OP_UNUSED;
		end
		d = $urandom_range(255);
		if (op == OP_WRITE) begin
			d = $urandom_range(3);
			if (height == int'(HEIGHT_MIN) && $urandom_range(1))
				d = $urandom_range(1) ? 128 : 255;
			else if (height == int'(HEIGHT_MAX) && $urandom_range(3) == 0)
				d = 255;
		end
		if (op == OP_WRITE && off < cells)
			written_cells.push_back(off);
		issue_access(op, off, $urandom, d);
	endtask

	initial begin : stimulus
		int a, phase, rows, cols, font_loads;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_READ;
		offset = '0;
		font_address = '0;
		data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CHAR_HEIGHT;
		cfg_data = '0;
		idle_pct = 0;
		items_sent = 0;
		reg_writes = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		// screen clear sweep after reset
		repeat (2) @(negedge clk);
		while (busy) @(negedge clk);

		// glyphs of codes 0 to 3 at every height, code 128 at 8 rows and
		// code 255 at 8 and 16 rows, so no glyph row reads an unwritten byte
		for (a = 0; a < 64; a++)
			issue_access(OP_FONT, $urandom, a, $urandom);
		for (a = 128 * 8; a < 128 * 8 + 8; a++)
			issue_access(OP_FONT, $urandom, a, $urandom);
		for (a = 255 * 8; a < 255 * 8 + 8; a++)
			issue_access(OP_FONT, $urandom, a, $urandom);
		for (a = 255 * 16; a < 255 * 16 + 16; a++)
			issue_access(OP_FONT, $urandom, a, $urandom);
		font_loads = items_sent;
		drain;

		// reset sizes: 25 x 80, 8-row glyphs
		issue_access(OP_READ, 0, 0, 0);
		issue_access(OP_READ, 1999, 0, 0);
		issue_access(OP_READ, 2000, 0, 0);
		issue_access(OP_READ, 16383, 4095, 255);
		issue_access(OP_WRITE, 0, 0, 0);
		issue_access(OP_WRITE, 1999, 0, 255);
		issue_access(OP_WRITE, 2000, 0, 8'h41);
		issue_access(OP_WRITE, 16383, 4095, 255);
		issue_access(OP_READ, 0, 0, 0);
		issue_access(OP_READ, 1999, 0, 0);
		issue_access(OP_UNUSED, 0, 0, 0);
		issue_access(OP_UNUSED, 16383, 4095, 255);
		issue_access(OP_FONT, 0, 0, 8'hFF);
		issue_access(OP_FONT, 16383, 4095, 8'h80);
		issue_access(OP_FONT, 0, 7, 8'h00);
		issue_access(OP_WRITE, 80, 0, 0);
		issue_access(OP_READ, 80, 0, 0);
		drain;

		// values past the used range saturate; index 3 is no register
		write_register(REG_CHAR_HEIGHT, 8'hFF);
		write_register(REG_SCREEN_ROWS, 8'h00);
		write_register(REG_SCREEN_COLS, 8'hFF);
		write_register(REG_UNUSED, 8'hAA);
		issue_access(OP_WRITE, 15 * 132 - 1, 0, 255);
		issue_access(OP_READ, 15 * 132, 0, 0);
		issue_access(OP_WRITE, 15 * 132 - 1, 0, 0);
		drain;
		write_register(REG_CHAR_HEIGHT, 8'h03);
		write_register(REG_SCREEN_ROWS, 8'hFF);
		write_register(REG_SCREEN_COLS, 8'h00);
		issue_access(OP_WRITE, 75 * 32 - 1, 0, 128);
		issue_access(OP_READ, 75 * 32, 0, 0);
		issue_access(OP_WRITE, 75 * 32, 0, 1);

		for (phase = 0; phase < PHASES; phase++) begin
			drain;
			case (phase)
				0: begin
					a = int'(HEIGHT_MIN);
					rows = int'(ROWS_MIN);
					cols = int'(COLS_MIN);
				end
				1: begin
					a = int'(HEIGHT_MAX);
					rows = int'(ROWS_MAX);
					cols = int'(COLS_MAX);
				end
				2: begin
					a = int'(HEIGHT_MIN);
					rows = int'(ROWS_RST);
					cols = int'(COLS_RST);
				end
				default: begin
					a = $urandom_range(int'(HEIGHT_MAX), int'(HEIGHT_MIN));
					rows = $urandom_range(int'(ROWS_MAX), int'(ROWS_MIN));
					cols = $urandom_range(int'(COLS_MAX), int'(COLS_MIN));
				end
			endcase
			write_register(REG_CHAR_HEIGHT, a);
			write_register(REG_SCREEN_ROWS, rows);
			write_register(REG_SCREEN_COLS, cols);
			idle_pct = (phase % 3 == 0) ? 20 : (phase % 3 == 1) ? 70 : 0;
			written_cells.delete();
			repeat (PHASE_ITEMS) random_access(rows * cols, a);
		end

		drain;
		repeat (40) @(negedge clk);
		$display("Covered %0d requests (incl. %0d font preload writes) and %0d register writes",
				items_sent, font_loads, reg_writes);
		$display("over %0d size settings; %0d results checked.", PHASES + 3, results_checked);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tsgr_pkg.sv
src/tsgr_ctrl.sv
src/tsgr_datapath.sv
src/text_screen_glyph_renderer.sv
test/tsgr_result_checker.sv
test/tb_text_screen_glyph_renderer.sv
